[hdl/pcf_pkg.sv]
// pcf_pkg: shared widths, constants, CORDIC angle table and sequencer type
// for the pitch complementary filter. No dependencies.
package pcf_pkg;

	localparam int CORDIC_W = 34;
	localparam int ANGLE_W  = 26;
	localparam int RATE_W   = 33;
	localparam int DELTA_W  = 33;
	localparam int PRED_W   = 34;
	localparam int ERR_W    = 35;
	localparam int MULB_W   = 24;
	localparam int PROD_W   = ERR_W + MULB_W + 1;
	localparam int NPITCH_W = 45;
	localparam int NBIAS_W  = 53;
	localparam int PITCH_W  = 25;
	localparam int BIAS_W   = 32;
	localparam int ATAN_LEN = 24;
	localparam int IT_W     = 5;

	localparam logic signed [PITCH_W-1:0] PITCH_LIMIT = 25'sd11796480;

	localparam logic [2:0] CFG_BLEND_GAIN = 3'd0;
	localparam logic [2:0] CFG_BIAS_GAIN  = 3'd1;
	localparam logic [2:0] CFG_GYRO_SCALE = 3'd2;
	localparam logic [2:0] CFG_TILT_ON    = 3'd3;
	localparam logic [2:0] CFG_TILT_OFF   = 3'd4;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_MULG = 9'b000000010,
		ST_PRED = 9'b000000100,
		ST_CORD = 9'b000001000,
		ST_ERR  = 9'b000010000,
		ST_MULB = 9'b000100000,
		ST_MULC = 9'b001000000,
		ST_UPD  = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	// atan(2^-i) in Q10.16 degrees
	function automatic logic signed [ANGLE_W-1:0] atan_q16(input logic [IT_W-1:0] i);
		logic signed [ANGLE_W-1:0] r;
		case (i)
			5'd0:  r = 26'sd2949120;
			5'd1:  r = 26'sd1740967;
			5'd2:  r = 26'sd919879;
			5'd3:  r = 26'sd466945;
			5'd4:  r = 26'sd234379;
			5'd5:  r = 26'sd117304;
			5'd6:  r = 26'sd58666;
			5'd7:  r = 26'sd29335;
			5'd8:  r = 26'sd14668;
			5'd9:  r = 26'sd7334;
			5'd10: r = 26'sd3667;
			5'd11: r = 26'sd1833;
			5'd12: r = 26'sd917;
			5'd13: r = 26'sd458;
			5'd14: r = 26'sd229;
			5'd15: r = 26'sd115;
			5'd16: r = 26'sd57;
			5'd17: r = 26'sd29;
			5'd18: r = 26'sd14;
			5'd19: r = 26'sd7;
			5'd20: r = 26'sd4;
			5'd21: r = 26'sd2;
			5'd22: r = 26'sd1;
			default: r = 26'sd0;
		endcase
		return r;
	endfunction

endpackage

[hdl/pitch_complementary_filter.sv]
// pitch_complementary_filter: complementary pitch filter with gyro bias estimation,
// CORDIC accelerometer pitch and a shared multiplier under a one-hot sequencer.
// Depends on pcf_pkg.
//
//  channel  | direction | transfer when        | payload
//  s_*      | in        | s_tvalid & s_tready  | tdata: accel_x, accel_z, gyro_y
//  m_*      | out       | m_tvalid & m_tready  | tdata: pitch_estimate, bias_estimate; tuser: tilted
//  cfg_*    | in        | cfg_valid & cfg_ready| cfg_index, cfg_data
//
// One sample runs through the sequencer, with min(CORDIC_STEPS, 24) CORDIC rotations at
// one rotation a cycle, before the earliest next input transfer is taken.
// The multiplier is shared by the gyro, blend and bias products.
// s_tready is high only while the sequencer is idle; the result register lets
// a new sample in while the last result waits, and the final step holds until
// that register is free. Reset clears pitch, bias and tilt and restores the gains.
module pitch_complementary_filter #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // accel_x[15:0], accel_z[31:16], gyro_y[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // pitch_estimate[24:0], bias_estimate[56:25], zero pad
	output logic [0:0]  m_tuser,   // tilted[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int STEPS = (CORDIC_STEPS < pcf_pkg::ATAN_LEN) ? CORDIC_STEPS
	                                                          : pcf_pkg::ATAN_LEN;
	localparam logic [pcf_pkg::IT_W-1:0] LAST_IT = pcf_pkg::IT_W'(STEPS - 1);

	localparam int CW  = pcf_pkg::CORDIC_W;
	localparam int ZW  = pcf_pkg::ANGLE_W;
	localparam int PW  = pcf_pkg::PROD_W;

	localparam logic signed [PW-1:0] RND_G = PW'(64'sd8388608);
	localparam logic signed [PW-1:0] RND_B = PW'(64'sd32768);
	localparam logic signed [PW-1:0] RND_C = PW'(64'sd128);
	localparam logic signed [ZW-1:0] ZLIM  = ZW'(pcf_pkg::PITCH_LIMIT);

	pcf_pkg::state_t state_q;

	logic [15:0]       blend_gain_q;
	logic [15:0]       bias_gain_q;
	logic [23:0]       gyro_scale_q;
	logic signed [8:0] tilt_on_q;
	logic signed [8:0] tilt_off_q;

	logic signed [pcf_pkg::PITCH_W-1:0] pitch_q;
	logic signed [pcf_pkg::BIAS_W-1:0]  bias_q;
	logic                               tilt_q;

	logic signed [CW-1:0]               x_q, y_q;
	logic signed [ZW-1:0]               z_q;
	logic                               zero_q;
	logic [pcf_pkg::IT_W-1:0]           it_q;
	logic signed [pcf_pkg::RATE_W-1:0]  rate_q;
	logic signed [PW-1:0]               prod_q;
	logic signed [pcf_pkg::PRED_W-1:0]  pred_q;
	logic signed [pcf_pkg::ERR_W-1:0]   err_q;
	logic signed [pcf_pkg::NPITCH_W-1:0] npitch_q;

	logic                out_valid_q;
	logic [63:0]         out_data_q;
	logic                out_tilt_q;

	logic signed [15:0]  ax, az, gy;
	logic signed [CW-1:0] ax_s, az_s, xs, ys;
	logic signed [ZW-1:0] atan_v, z_clamp;
	logic signed [pcf_pkg::ERR_W-1:0] mul_a;
	logic [pcf_pkg::MULB_W-1:0] mul_b;
	logic signed [PW-1:0] product, g_sh, b_sh, c_sh;
	logic signed [pcf_pkg::DELTA_W-1:0] delta;
	logic signed [ZW-1:0] acc;
	logic signed [pcf_pkg::NBIAS_W-1:0] nbias_w;
	logic signed [pcf_pkg::PITCH_W-1:0] npitch_c;
	logic signed [pcf_pkg::BIAS_W-1:0]  nbias_c;
	logic signed [pcf_pkg::PITCH_W-1:0] on_th, off_th;
	logic in_xfer;

	assign s_tready  = (state_q == pcf_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tuser   = out_tilt_q;

	assign ax   = $signed(s_tdata[15:0]);
	assign az   = $signed(s_tdata[31:16]);
	assign gy   = $signed(s_tdata[47:32]);
	assign ax_s = CW'(ax) <<< 14;
	assign az_s = CW'(az) <<< 14;

	assign xs     = x_q >>> it_q;
	assign ys     = y_q >>> it_q;
	assign atan_v = pcf_pkg::atan_q16(it_q);

	always_comb begin
		mul_a = err_q;
		mul_b = {8'd0, blend_gain_q};
		case (state_q)
			pcf_pkg::ST_MULG: begin
				mul_a = pcf_pkg::ERR_W'(rate_q);
				mul_b = gyro_scale_q;
			end
			pcf_pkg::ST_MULC: begin
				mul_b = {8'd0, bias_gain_q};
			end
			default: begin
				mul_b = {8'd0, blend_gain_q};
			end
		endcase
	end

	assign product = mul_a * $signed({1'b0, mul_b});

	assign g_sh  = (prod_q + RND_G) >>> 24;
	assign b_sh  = (prod_q + RND_B) >>> 16;
	assign c_sh  = (prod_q + RND_C) >>> 8;
	assign delta = $signed(g_sh[pcf_pkg::DELTA_W-1:0]);

	assign z_clamp = (z_q > ZLIM) ? ZLIM : ((z_q < -ZLIM) ? -ZLIM : z_q);
	assign acc     = zero_q ? '0 : z_clamp;

	assign nbias_w = pcf_pkg::NBIAS_W'(bias_q) - $signed(c_sh[pcf_pkg::NBIAS_W-1:0]);

	always_comb begin
		if (npitch_q > pcf_pkg::NPITCH_W'(pcf_pkg::PITCH_LIMIT))
			npitch_c = pcf_pkg::PITCH_LIMIT;
		else if (npitch_q < -pcf_pkg::NPITCH_W'(pcf_pkg::PITCH_LIMIT))
			npitch_c = -pcf_pkg::PITCH_LIMIT;
		else
			npitch_c = npitch_q[pcf_pkg::PITCH_W-1:0];
		if (nbias_w > pcf_pkg::NBIAS_W'(33'sh0_7FFF_FFFF))
			nbias_c = 32'sh7FFF_FFFF;
		else if (nbias_w < pcf_pkg::NBIAS_W'(33'sh1_8000_0000))
			nbias_c = 32'sh8000_0000;
		else
			nbias_c = nbias_w[pcf_pkg::BIAS_W-1:0];
	end

	assign on_th  = {tilt_on_q, 16'd0};
	assign off_th = {tilt_off_q, 16'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_gain_q <= 16'd32768;
			bias_gain_q  <= 16'd1280;
			gyro_scale_q <= 24'd16777;
			tilt_on_q    <= -9'sd6;
			tilt_off_q   <= 9'sd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pcf_pkg::CFG_BLEND_GAIN: blend_gain_q <= cfg_data[15:0];
				pcf_pkg::CFG_BIAS_GAIN:  bias_gain_q  <= cfg_data[15:0];
				pcf_pkg::CFG_GYRO_SCALE: gyro_scale_q <= cfg_data;
				pcf_pkg::CFG_TILT_ON:    tilt_on_q    <= $signed(cfg_data[8:0]);
				pcf_pkg::CFG_TILT_OFF:   tilt_off_q   <= $signed(cfg_data[8:0]);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcf_pkg::ST_IDLE;
			pitch_q     <= '0;
			bias_q      <= '0;
			tilt_q      <= 1'b0;
			it_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == pcf_pkg::ST_DONE && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				pcf_pkg::ST_IDLE: begin
					if (in_xfer)
						state_q <= pcf_pkg::ST_MULG;
				end
				pcf_pkg::ST_MULG: state_q <= pcf_pkg::ST_PRED;
				pcf_pkg::ST_PRED: begin
					it_q    <= '0;
					state_q <= pcf_pkg::ST_CORD;
				end
				pcf_pkg::ST_CORD: begin
					it_q <= it_q + 1'b1;
					if (it_q == LAST_IT)
						state_q <= pcf_pkg::ST_ERR;
				end
				pcf_pkg::ST_ERR:  state_q <= pcf_pkg::ST_MULB;
				pcf_pkg::ST_MULB: state_q <= pcf_pkg::ST_MULC;
				pcf_pkg::ST_MULC: state_q <= pcf_pkg::ST_UPD;
				pcf_pkg::ST_UPD: begin
					pitch_q <= npitch_c;
					bias_q  <= nbias_c;
					if (npitch_c < on_th)
						tilt_q <= 1'b1;
					else if (npitch_c > off_th)
						tilt_q <= 1'b0;
					state_q <= pcf_pkg::ST_DONE;
				end
				pcf_pkg::ST_DONE: begin
					if (!out_valid_q || m_tready)
						state_q <= pcf_pkg::ST_IDLE;
				end
				default: state_q <= pcf_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pcf_pkg::ST_IDLE: begin
				if (in_xfer) begin
					zero_q <= (ax == 16'sd0) && (az == 16'sd0);
					rate_q <= $signed({gy, 16'd0}) - pcf_pkg::RATE_W'(bias_q);
					if (az < 0) begin
						x_q <= -az_s;
						y_q <= ax_s;
						z_q <= (ax <= 0) ? ZLIM : -ZLIM;
					end else begin
						x_q <= az_s;
						y_q <= -ax_s;
						z_q <= '0;
					end
				end
			end
			pcf_pkg::ST_MULG: prod_q <= product;
			pcf_pkg::ST_PRED: begin
				pred_q <= pcf_pkg::PRED_W'(pitch_q) + pcf_pkg::PRED_W'(delta);
			end
			pcf_pkg::ST_CORD: begin
				if (!y_q[CW-1]) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_v;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_v;
				end
			end
			pcf_pkg::ST_ERR: begin
				err_q <= pcf_pkg::ERR_W'(acc) - pcf_pkg::ERR_W'(pred_q);
			end
			pcf_pkg::ST_MULB: prod_q <= product;
			pcf_pkg::ST_MULC: begin
				npitch_q <= pcf_pkg::NPITCH_W'(pred_q)
				          + $signed(b_sh[pcf_pkg::NPITCH_W-1:0]);
				prod_q   <= product;
			end
			pcf_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_data_q <= {7'd0, bias_q, pitch_q};
					out_tilt_q <= tilt_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/pcf_checker.sv]
// pcf_checker: port-level assertions for pitch_complementary_filter, bound to
// the top level below. Depends on the top level's port list only.
module pcf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// one sample in flight: no second transfer straight after one
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a sample is in flight");

	// a result appears only as the sequencer leaves its busy phase
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised without a sample in flight");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[24:0]) <= 25'sd11796480)
		          && ($signed(m_tdata[24:0]) >= -25'sd11796480))
		else $error("pitch outside +-180 degrees");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind pitch_complementary_filter pcf_checker u_pcf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);
